// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/bezier_pkg.sv -----
// Package: types, constants and command/status structs for the Bezier sampler
`default_nettype none
package bezier_pkg;
    localparam int MAX_POINTS  = 16;
    localparam int MAX_SAMPLES = 64;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = $clog2(MAX_SAMPLES + 1);
    localparam int BW = 13;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } request_t;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
        logic               last_sample;
        logic               points_dropped;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROW, ST_TDIV, ST_TERM, ST_POW, ST_WEIGHT,
        ST_MAC, ST_ROUND, ST_EMIT
    } state_t;

    typedef struct packed {
        logic row_init;
        logic row_step;
        logic tdiv_start;
        logic term_init;
        logic pow_step;
        logic weight;
        logic mac;
        logic round;
        logic emit;
        logic next_sample;
        logic next_term;
    } cmd_t;

    typedef struct packed {
        logic row_done;
        logic tdiv_done;
        logic pow_done;
        logic term_last;
        logic mac_done;
        logic sample_last;
    } status_t;
endpackage
`default_nettype wire

// ----- rtl/bezier_curve_sampler_core.sv -----
// Top level of the Bezier curve sampler
// A point without last_point is stored while room remains; busy stays low.
// A closing point runs the row build, then per sample the t division, the power,
// weight and MAC steps for each term, and the round and emit steps.
// One result is emitted per sample.
// Reset (rst_n, async low) clears counts, flags and the controller; results
// are strobed for one cycle and the receiver cannot stall them.
`default_nettype none
module bezier_curve_sampler_core
    import bezier_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      start,
    output logic     busy,
    input  request_t request,
    input  wire      cfg_we,
    input  wire [6:0] cfg_wdata,
    output logic     result_valid,
    output result_t  result
);
    cmd_t    cmd;
    status_t status;
    logic    run;
    logic    accept;
    logic [6:0] num_samples_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_samples_reg <= 7'd16;
        else if (cfg_we)
            num_samples_reg <= cfg_wdata;
    end

    bezier_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .run    (run),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bezier_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (accept),
        .req          (request),
        .num_samples  (num_samples_reg),
        .cmd          (cmd),
        .status       (status),
        .run          (run),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule
`default_nettype wire

// ----- rtl/bezier_ctrl.sv -----
// Controller state machine for the Bezier sampler
`default_nettype none
`include "assert_macros.svh"
module bezier_ctrl
    import bezier_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     run,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (run) state_next = ST_ROW;
            ST_ROW:    if (status.row_done) state_next = ST_TDIV;
            ST_TDIV:   if (status.tdiv_done) state_next = ST_TERM;
            ST_TERM:   state_next = ST_POW;
            ST_POW:    if (status.pow_done) state_next = ST_WEIGHT;
            ST_WEIGHT: state_next = ST_MAC;
            ST_MAC:    if (status.mac_done)
                           state_next = status.term_last ? ST_ROUND : ST_TERM;
            ST_ROUND:  state_next = ST_EMIT;
            ST_EMIT:   state_next = status.sample_last ? ST_IDLE : ST_TDIV;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.row_init = run;
            ST_ROW:    begin
                           cmd.row_step = 1'b1;
                           cmd.tdiv_start = status.row_done;
                       end
            ST_TDIV:   cmd.term_init = status.tdiv_done;
            ST_POW:    cmd.pow_step = 1'b1;
            ST_WEIGHT: cmd.weight = 1'b1;
            ST_MAC:    begin
                           cmd.mac = 1'b1;
                           cmd.next_term = status.mac_done && !status.term_last;
                       end
            ST_ROUND:  cmd.round = 1'b1;
            ST_EMIT:   begin
                           cmd.emit = 1'b1;
                           cmd.next_sample = 1'b1;
                           cmd.tdiv_start = !status.sample_last;
                       end
            default:   cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `ASSERT_IMPL(a_run_leaves_idle, clk, rst_n,
        (state_reg == ST_IDLE && run) |=> state_reg == ST_ROW)
    `ASSERT_IMPL(a_emit_then_move, clk, rst_n,
        (state_reg == ST_EMIT) |=> (state_reg == ST_IDLE || state_reg == ST_TDIV))
    `ASSERT_NEVER(a_emit_and_mac, clk, rst_n, cmd.emit && cmd.mac)
endmodule
`default_nettype wire

// ----- rtl/bezier_dp.sv -----
// Datapath for the Bezier sampler: point store, binomial row, t divider, MAC
`default_nettype none
`include "assert_macros.svh"
module bezier_dp
    import bezier_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      req_valid,
    input  request_t req,
    input  wire [6:0] num_samples,
    input  cmd_t     cmd,
    output status_t  status,
    output logic     run,
    output logic     result_valid,
    output result_t  result
);
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [31:0] mem_z [MAX_POINTS];
    logic [BW-1:0] row_reg [MAX_POINTS];

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          dropped_reg;
    logic [PW-1:0] n_reg;
    logic [PW-1:0] r_reg;
    logic [SW-1:0] ns_reg;
    logic [SW-1:0] i_reg;
    logic [PW-1:0] k_reg;
    logic [PW-1:0] j_reg;
    logic [24:0]   t_reg, u_reg, p_reg;
    logic [24:0]   w_reg;
    logic [4:0]    div_cnt_reg;
    logic [17:0]   quo_reg;
    logic [23:0]   rem_reg;
    logic [1:0]    mac_ph_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [63:0] ax_reg, ay_reg, az_reg;
    logic signed [57:0] prod_reg;
    result_t res_reg;
    logic    res_valid_reg;

    logic          store_ok;
    logic [SW-1:0] ns_eff;
    logic [SW-1:0] d_val;
    logic [23:0]   num_val;
    logic [24:0]   rem_try;
    logic [49:0]   pow_prod;
    logic [37:0]   wprod;
    logic [24:0]   pow_x;
    logic signed [31:0] mac_c;

    assign store_ok = (count_reg < CW'(MAX_POINTS));
    assign run = req_valid && req.last_point;

    always_comb
    begin
        ns_eff = SW'(num_samples);
        if (num_samples < 7'd2)
            ns_eff = SW'(2);
        else if (num_samples > 7'(MAX_SAMPLES))
            ns_eff = SW'(MAX_SAMPLES);
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && store_ok) begin
            mem_x[count_reg[PW-1:0]] <= req.point_x;
            mem_y[count_reg[PW-1:0]] <= req.point_y;
            mem_z[count_reg[PW-1:0]] <= req.point_z;
        end
        cx_reg <= mem_x[k_reg];
        cy_reg <= mem_y[k_reg];
        cz_reg <= mem_z[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            dropped_reg <= 1'b0;
        end else if (req_valid) begin
            if (req.last_point) begin
                dropped_reg <= ovf_reg || !store_ok;
                count_reg   <= '0;
                ovf_reg     <= 1'b0;
            end else if (store_ok) begin
                count_reg <= count_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // binomial row: one row per cycle via a parallel Pascal update
    always_ff @(posedge clk)
    begin
        if (cmd.row_init) begin
            n_reg  <= store_ok ? count_reg[PW-1:0] : PW'(MAX_POINTS - 1);
            ns_reg <= ns_eff;
            r_reg  <= '0;
            row_reg[0] <= BW'(1);
        end else if (cmd.row_step && !status.row_done) begin
            r_reg <= r_reg + 1'b1;
            for (int m = 1; m < MAX_POINTS; m++) begin
                if (PW'(m) == r_reg + 1'b1)
                    row_reg[m] <= BW'(1);
                else if (PW'(m) <= r_reg)
                    row_reg[m] <= row_reg[m] + row_reg[m-1];
            end
        end
    end
    assign status.row_done = (r_reg == n_reg);

    // t = round(i*65536/d): restoring division, one bit a cycle
    assign d_val   = ns_reg - 1'b1;
    assign num_val = 24'(i_reg) * 24'd131072 + 24'(d_val);
    assign rem_try = {rem_reg, num_val[5'd23 - div_cnt_reg]} - {d_val, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.row_init) begin
            i_reg <= '0;
        end else if (cmd.next_sample) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.tdiv_start) begin
            div_cnt_reg <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end else if (!status.tdiv_done) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!rem_try[24]) begin
                rem_reg <= rem_try[23:0];
                quo_reg <= {quo_reg[16:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[22:0], num_val[5'd23 - div_cnt_reg]};
                quo_reg <= {quo_reg[16:0], 1'b0};
            end
        end
    end
    assign status.tdiv_done = (div_cnt_reg == 5'd24);

    // per term: power product, weight, multiply-accumulate
    assign pow_x    = (j_reg < k_reg) ? t_reg : u_reg;
    assign pow_prod = 50'(p_reg) * 50'(pow_x) + 50'(1 << 23);
    assign wprod    = 38'(row_reg[k_reg]) * 38'(p_reg);
    assign mac_c    = (mac_ph_reg == 2'd0) ? cx_reg :
                      (mac_ph_reg == 2'd1) ? cy_reg : cz_reg;
    assign status.pow_done  = (j_reg == n_reg);
    assign status.term_last = (k_reg == n_reg);
    assign status.mac_done  = (mac_ph_reg == 2'd3);
    assign status.sample_last = (i_reg == ns_reg - 1'b1);

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] a);
        logic signed [63:0] v;
        logic signed [39:0] q;
        v = a + 64'sd8388608;
        q = 40'(v >>> 24);
        if (q > 40'sd2147483647)       round_sat = 32'sh7fffffff;
        else if (q < -40'sd2147483648) round_sat = 32'sh80000000;
        else                           round_sat = q[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.term_init) begin
            t_reg <= (quo_reg >= 18'h10000) ? 25'h1000000 : {quo_reg[16:0], 8'd0};
            u_reg <= 25'h1000000 - ((quo_reg >= 18'h10000) ? 25'h1000000
                                                          : {quo_reg[16:0], 8'd0});
            k_reg <= '0;
            j_reg <= '0;
            p_reg <= 25'h1000000;
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
        end
        if (cmd.next_term) begin
            k_reg <= k_reg + 1'b1;
            j_reg <= '0;
            p_reg <= 25'h1000000;
        end
        if (cmd.pow_step && !status.pow_done) begin
            p_reg <= pow_prod[48:24];
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.weight) begin
            w_reg <= (wprod > 38'h1000000) ? 25'h1000000 : wprod[24:0];
            mac_ph_reg <= '0;
        end
        if (cmd.mac) begin
            mac_ph_reg <= mac_ph_reg + 1'b1;
            prod_reg <= $signed({1'b0, w_reg}) * mac_c;
            unique case (mac_ph_reg)
                2'd1: ax_reg <= ax_reg + 64'(prod_reg);
                2'd2: ay_reg <= ay_reg + 64'(prod_reg);
                2'd3: az_reg <= az_reg + 64'(prod_reg);
                default: ;
            endcase
        end
        if (cmd.round) begin
            res_reg.sample_x <= round_sat(ax_reg);
            res_reg.sample_y <= round_sat(ay_reg);
            res_reg.sample_z <= round_sat(az_reg);
            res_reg.last_sample    <= status.sample_last;
            res_reg.points_dropped <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) res_valid_reg <= 1'b0;
        else        res_valid_reg <= cmd.emit;
    end

    assign result_valid = res_valid_reg;
    assign result = res_reg;

    `ASSERT_IMPL(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_POINTS))
    `ASSERT_IMPL(a_t_bound, clk, rst_n, cmd.pow_step |-> t_reg <= 25'h1000000)
    `ASSERT_IMPL(a_emit_valid, clk, rst_n, cmd.emit |=> result_valid)
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench for the Bezier curve sampler: directed and random control-point requests checked against a predictor
`default_nettype none
module testbench;
    import bezier_pkg::*;

    localparam longint CYCLE_LIMIT = 10000000;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    request_t request = '0;
    logic cfg_we;
    logic [6:0] cfg_wdata;
    logic result_valid;
    result_t result;

    bezier_curve_sampler_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    // predictor state
    logic signed [31:0] ctl_x [MAX_POINTS];
    logic signed [31:0] ctl_y [MAX_POINTS];
    logic signed [31:0] ctl_z [MAX_POINTS];
    int unsigned ctl_count = 0;
    bit ctl_overflow = 1'b0;
    int unsigned sample_setting;

    request_t pending_requests [$];
    result_t curve_points [$];
    int mismatches = 0;
    bit idle_enable;
    int gap_left = 0;
    longint cycle_count = 0;

    function automatic logic signed [31:0] round_q16(input logic signed [63:0] acc);
        logic signed [63:0] v;
        logic signed [63:0] q;
        begin
            v = acc + 64'sd8388608;
            q = v >>> 24;
            if (q > 64'sd2147483647)
                return 32'h7fffffff;
            if (q < -64'sd2147483648)
                return 32'h80000000;
            return q[31:0];
        end
    endfunction

    task automatic add_expected(input result_t item);
        curve_points.insert(curve_points.size(), item);
    endtask

    task automatic add_request(input request_t item);
        pending_requests.insert(pending_requests.size(), item);
    endtask

    task automatic predict_curve(input request_t req);
        int unsigned ns;
        int unsigned deg;
        longint unsigned row [MAX_POINTS];
        longint unsigned d;
        longint unsigned tq;
        longint unsigned t24;
        longint unsigned u24;
        longint unsigned p;
        longint unsigned w;
        logic signed [63:0] ax;
        logic signed [63:0] ay;
        logic signed [63:0] az;
        result_t r;
        begin
            if (ctl_count < MAX_POINTS) begin
                ctl_x[ctl_count] = req.point_x;
                ctl_y[ctl_count] = req.point_y;
                ctl_z[ctl_count] = req.point_z;
                ctl_count++;
            end else
                ctl_overflow = 1;
            if (!req.last_point)
                return;
            ns = sample_setting < 2 ? 2
               : (sample_setting > MAX_SAMPLES ? MAX_SAMPLES : sample_setting);
            deg = ctl_count - 1;
            row[0] = 1;
            for (int r2 = 1; r2 <= deg; r2++) begin
                row[r2] = 1;
                for (int k = r2 - 1; k >= 1; k--)
                    row[k] += row[k - 1];
            end
            d = ns - 1;
            for (int i = 0; i < ns; i++) begin
                tq = (longint'(i) * 131072 + d) / (2 * d);
                t24 = tq << 8;
                if (t24 > (64'd1 << 24))
                    t24 = 64'd1 << 24;
                u24 = (64'd1 << 24) - t24;
                ax = 0;
                ay = 0;
                az = 0;
                for (int k = 0; k <= deg; k++) begin
                    p = 64'd1 << 24;
                    for (int j = 0; j < k; j++)
                        p = (p * t24 + (64'd1 << 23)) >> 24;
                    for (int j = k; j < deg; j++)
                        p = (p * u24 + (64'd1 << 23)) >> 24;
                    w = row[k] * p;
                    if (w > (64'd1 << 24))
                        w = 64'd1 << 24;
                    ax += $signed(w) * 64'(ctl_x[k]);
                    ay += $signed(w) * 64'(ctl_y[k]);
                    az += $signed(w) * 64'(ctl_z[k]);
                end
                r.sample_x = round_q16(ax);
                r.sample_y = round_q16(ay);
                r.sample_z = round_q16(az);
                r.last_sample = (i == ns - 1);
                r.points_dropped = ctl_overflow;
                add_expected(r);
            end
            ctl_count = 0;
            ctl_overflow = 0;
        end
    endtask

    function automatic logic [31:0] pick_coord(input int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t make_point(input bit closing);
        request_t q;
        int mode;
        begin
            mode = $urandom_range(0, 9);
            q.point_x = pick_coord(mode < 1 ? 0 : (mode < 2 ? 1 : (mode < 6 ? 2 : 3)));
            mode = $urandom_range(0, 9);
            q.point_y = pick_coord(mode < 1 ? 0 : (mode < 2 ? 1 : (mode < 6 ? 2 : 3)));
            mode = $urandom_range(0, 9);
            q.point_z = pick_coord(mode < 1 ? 0 : (mode < 2 ? 1 : (mode < 6 ? 2 : 3)));
            q.last_point = closing;
            return q;
        end
    endfunction

    task automatic queue_curve(input int npts);
        for (int i = 0; i < npts; i++)
            add_request(make_point(i == npts - 1));
    endtask

    task automatic drain_and_settle();
        wait (pending_requests.size() == 0 && !start);
        @(posedge clk);
        wait (curve_points.size() == 0 && !busy);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_samples(input logic [6:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        sample_setting = {25'd0, value};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_requests.size() > 0 && !busy) begin
                if (idle_enable && $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(0, 6);
                    start <= 1'b0;
                end else begin
                    request <= pending_requests.pop_front();
                    start <= 1'b1;
                end
            end else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            cycle_count <= cycle_count + 1;
            if (start && !busy)
                predict_curve(request);
            if (result_valid) begin
                if (curve_points.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %p", result);
                    mismatches <= mismatches + 1;
                end else begin
                    result_t e;
                    e = curve_points.pop_front();
                    if (result.sample_x !== e.sample_x || result.sample_y !== e.sample_y ||
                        result.sample_z !== e.sample_z ||
                        result.last_sample !== e.last_sample ||
                        result.points_dropped !== e.points_dropped) begin
                        if (mismatches < 10)
                            $display("mismatch expected %p actual %p", e, result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        request_t q;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        idle_enable = 1;
        sample_setting = 16;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, single point, overflow, sample count limits
        q = '{32'h7fffffff, 32'h80000000, 32'h0, 1'b1};
        add_request(q);
        q = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0};
        add_request(q);
        q = '{32'h7fffffff, 32'h7fffffff, 32'h00010000, 1'b1};
        add_request(q);
        drain_and_settle();
        write_samples(7'd2);
        queue_curve(MAX_POINTS + 2);
        drain_and_settle();
        write_samples(7'd0);
        queue_curve(3);
        drain_and_settle();
        write_samples(7'd127);
        queue_curve(4);
        drain_and_settle();
        write_samples(7'd64);
        queue_curve(MAX_POINTS);
        drain_and_settle();

        // random: mostly small curves and sample counts
        for (int phase = 0; phase < 8; phase++) begin
            write_samples(phase == 3 ? 7'd1
                          : (phase == 5 ? 7'd64 : 7'($urandom_range(2, 12))));
            for (int c = 0; c < 12; c++)
                queue_curve($urandom_range(0, 9) == 0 ? $urandom_range(15, 19)
                                                      : $urandom_range(1, 5));
            if (phase == 7)
                idle_enable = 0;
            drain_and_settle();
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && curve_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
